@@ rtl/core/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 package
// Shared constants, S-box tables and round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int RkEntries = 2 * (NumRounds + 1);
  localparam int SchedWords = 4 * (NumRounds + 1);

  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  // datapath commands
  typedef struct packed {
    logic load;      // capture input block, add round key 0
    logic round;     // apply one round with key at round_idx
    logic last_rnd;  // final round, no mix columns
    logic decrypt;
    logic [3:0] round_idx;
  } dp_cmd_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  // one column of mix columns; byte 0 in top bits
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [3:0] m0, m1, m2, m3;
    logic [31:0] r;
    for (int i = 0; i < 4; i++) a[i] = c[31-8*i -: 8];
    m0 = inv ? 4'd14 : 4'd2;
    m1 = inv ? 4'd11 : 4'd3;
    m2 = inv ? 4'd13 : 4'd1;
    m3 = inv ? 4'd9 : 4'd1;
    for (int i = 0; i < 4; i++) begin
      r[31-8*i -: 8] = gmul(a[i], m0) ^ gmul(a[(i+1)%4], m1) ^
                       gmul(a[(i+2)%4], m2) ^ gmul(a[(i+3)%4], m3);
    end
    mix_col = r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

@@ rtl/core/aes_stream_if.sv @@
// ----------------------------------------------------------------------------
// AES stream interfaces
// Valid/ready channels for input and output words.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_in_high;
  logic [63:0] block_in_low;
  logic        last_in;
  modport source (output valid, func, block_in_high, block_in_low, last_in, input ready);
  modport sink (input valid, func, block_in_high, block_in_low, last_in, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out_high;
  logic [63:0] block_out_low;
  logic        last_out;
  modport source (output valid, block_out_high, block_out_low, last_out, input ready);
  modport sink (input valid, block_out_high, block_out_low, last_out, output ready);
endinterface

@@ rtl/core/aes_key_sched.sv @@
// ----------------------------------------------------------------------------
// AES key schedule
// Expands the key one schedule word per cycle, then derives decryption keys.
// ----------------------------------------------------------------------------
module aes_key_sched (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] key,
  input  logic         rd_decrypt,
  input  logic [3:0]   rd_idx,
  output logic [127:0] rd_key,
  output logic         busy
);

  localparam logic [1:0] KS_IDLE = 2'd0;
  localparam logic [1:0] KS_EXP = 2'd1;
  localparam logic [1:0] KS_DEC = 2'd2;

  logic [1:0] state;
  logic [5:0] widx;
  logic [3:0] didx;
  logic [31:0] win [8];
  logic [127:0] enc_keys [15];
  logic [127:0] dec_keys [15];
  logic [7:0] rcon;
  logic [31:0] t, wnew;
  logic [127:0] src, mixed;

  function automatic logic [31:0] sub_word_rot(input logic [31:0] w);
    sub_word_rot = aes_pkg::sub_word({w[23:0], w[31:24]});
  endfunction

  // next schedule word from the sliding window
  always_comb begin
    t = win[7];
    if (widx[2:0] == 3'd0) t = sub_word_rot(win[7]) ^ {rcon, 24'h0};
    else if (widx[2:0] == 3'd4) t = aes_pkg::sub_word(win[7]);
    wnew = win[0] ^ t;
  end

  // inverse mix on one enc key for the decryption table
  always_comb begin
    src = enc_keys[4'd14 - didx];
    for (int c = 0; c < 4; c++)
      mixed[127-32*c -: 32] = aes_pkg::mix_col(src[127-32*c -: 32], 1'b1);
    if (didx == 4'd0 || didx == 4'd14) mixed = src;
  end

  // a key write restarts the expansion from any state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KS_EXP;
      widx <= 6'd8;
      rcon <= 8'h01;
      didx <= 4'd0;
      for (int i = 0; i < 8; i++) win[i] <= 32'h0;
      enc_keys[0] <= 128'h0;
      enc_keys[1] <= 128'h0;
    end else if (start) begin
      state <= KS_EXP;
      widx <= 6'd8;
      rcon <= 8'h01;
      for (int i = 0; i < 8; i++) win[i] <= key[255-32*i -: 32];
      enc_keys[0] <= key[255:128];
      enc_keys[1] <= key[127:0];
    end else begin
      case (state)
        KS_IDLE: state <= KS_IDLE;
        KS_EXP: begin
          for (int i = 0; i < 7; i++) win[i] <= win[i+1];
          win[7] <= wnew;
          enc_keys[widx[5:2]][127-32*widx[1:0] -: 32] <= wnew;
          if (widx[2:0] == 3'd0) rcon <= aes_pkg::xt(rcon);
          if (widx == 6'(aes_pkg::SchedWords - 1)) begin
            state <= KS_DEC;
            didx <= 4'd0;
          end
          widx <= widx + 6'd1;
        end
        KS_DEC: begin
          dec_keys[didx] <= mixed;
          didx <= didx + 4'd1;
          if (didx == 4'd14) state <= KS_IDLE;
        end
        default: state <= KS_IDLE;
      endcase
    end
  end

  assign rd_key = rd_decrypt ? dec_keys[rd_idx] : enc_keys[rd_idx];
  assign busy = (state != KS_IDLE) || start;

endmodule

@@ rtl/core/aes_datapath.sv @@
// ----------------------------------------------------------------------------
// AES round datapath
// State register and one shared round unit, encrypt or decrypt.
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic              clk,
  input  aes_pkg::dp_cmd_t  cmd,
  input  logic [127:0]      blk,
  input  logic              last_in,
  input  logic [127:0]      rkey,
  output logic [127:0]      state_q,
  output logic              last_q
);

  logic [127:0] sb, sr, mc, rout;
  logic [7:0] b [16];
  logic [7:0] o [16];

  // sub bytes and shift rows commute, do sub first
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = cmd.decrypt ? aes_pkg::inv_sbox(state_q[127-8*i -: 8])
                         : aes_pkg::sbox(state_q[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd.decrypt) o[r + 4*((c+r)%4)] = b[r + 4*c];
        else o[r + 4*c] = b[r + 4*((c+r)%4)];
      end
    end
    for (int i = 0; i < 16; i++) sr[127-8*i -: 8] = o[i];
    sb = sr;
    for (int c = 0; c < 4; c++)
      mc[127-32*c -: 32] = aes_pkg::mix_col(sb[127-32*c -: 32], cmd.decrypt);
    rout = (cmd.last_rnd ? sb : mc) ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_q <= blk ^ rkey;
      last_q <= last_in;
    end else if (cmd.round) begin
      state_q <= rout;
    end
  end

endmodule

@@ rtl/core/aes_ctrl.sv @@
// ----------------------------------------------------------------------------
// AES controller
// Sequences load, fourteen rounds and the output handshake.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             func,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             ks_busy,
  output aes_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [3:0] rnd;
  logic dec;
  logic take;

  assign in_ready = (state == ST_IDLE) && !ks_busy;
  assign take = in_valid && in_ready;
  assign out_valid = (state == ST_DONE);

  always_comb begin
    cmd.load = take;
    cmd.round = (state == ST_RUN);
    cmd.last_rnd = (rnd == 4'(aes_pkg::NumRounds));
    cmd.decrypt = take ? func : dec;
    cmd.round_idx = take ? 4'd0 : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd <= 4'd0;
      dec <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (take) begin
          state <= ST_RUN;
          rnd <= 4'd1;
          dec <= func;
        end
        ST_RUN: begin
          rnd <= rnd + 4'd1;
          if (rnd == 4'(aes_pkg::NumRounds)) state <= ST_DONE;
        end
        ST_DONE: if (out_ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // round counter stays in range while running
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rnd >= 4'd1 && rnd <= 4'(aes_pkg::NumRounds)))
    else $error("round counter out of range");
  // no new word taken while working
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
  // last round leads to done
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && rnd == 4'(aes_pkg::NumRounds)) |=> (state == ST_DONE))
    else $error("missed done");

endmodule

@@ rtl/core/aes256_block_cipher.sv @@
// A word is loaded, runs 14 rounds, then holds its output until the receiver takes it;
// no new word is accepted before that output handshake completes.
// After reset or a key write the schedule runs 52 words then 15 inverse-mix steps
// before the next word is taken.
// Reset: synchronous, active high; key resets to zero and is expanded.
// ----------------------------------------------------------------------------
// AES-256 block cipher
// Single-block ECB encrypt and decrypt with on-chip key expansion.
// ----------------------------------------------------------------------------
module aes256_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  aes_in_if.sink      din,
  aes_out_if.source   dout
);

  logic [255:0] key, key_next;
  logic ks_busy;
  logic [127:0] rkey, st;
  logic lastq;
  aes_pkg::dp_cmd_t cmd;

  // key register update
  always_comb begin
    key_next = key;
    if (cfg_we) begin
      case (cfg_index)
        aes_pkg::REG_KEY0: key_next[255:192] = cfg_data;
        aes_pkg::REG_KEY1: key_next[191:128] = cfg_data;
        aes_pkg::REG_KEY2: key_next[127:64] = cfg_data;
        aes_pkg::REG_KEY3: key_next[63:0] = cfg_data;
        default: key_next = key;
      endcase
    end
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= 256'h0;
    end else begin
      key <= key_next;
    end
  end

  aes_key_sched u_ks (
    .clk(clk), .rst(rst), .start(cfg_we), .key(key_next),
    .rd_decrypt(cmd.decrypt), .rd_idx(cmd.round_idx), .rd_key(rkey), .busy(ks_busy)
  );

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(din.valid), .func(din.func), .in_ready(din.ready),
    .out_valid(dout.valid), .out_ready(dout.ready), .ks_busy(ks_busy), .cmd(cmd)
  );

  aes_datapath u_dp (
    .clk(clk), .cmd(cmd), .blk({din.block_in_high, din.block_in_low}),
    .last_in(din.last_in), .rkey(rkey), .state_q(st), .last_q(lastq)
  );

  assign dout.block_out_high = st[127:64];
  assign dout.block_out_low = st[63:0];
  assign dout.last_out = lastq;

endmodule

@@ dv/aes256_block_cipher_checker.sv @@
// ----------------------------------------------------------------------------
// AES-256 block cipher checker
// Watches the key write port and both word channels, predicts each output
// word with its own AES-256 encrypt/decrypt model and compares field by field.
// ----------------------------------------------------------------------------
module aes256_block_cipher_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  aes_in_if.sink      din,
  aes_out_if.sink     dout,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_word_t;

  logic [63:0]  key_words [4];
  logic [127:0] enc_keys [aes_pkg::NumRounds+1];
  logic [127:0] dec_keys [aes_pkg::NumRounds+1];
  cipher_word_t expected_words [$];

  // gf(2^8) multiply by full byte
  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inverse(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = gf_mult(r, a);
    return r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(input logic [7:0] a);
    logic [7:0] x;
    x = gf_inverse(a);
    return x ^ rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 3) ^ rotl(x, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(input logic [7:0] a);
    return gf_inverse(rotl(a, 1) ^ rotl(a, 3) ^ rotl(a, 6) ^ 8'h05);
  endfunction

  // state byte i at bits 127-8i
  function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [127:0] r;
    if (inv) begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end else begin
      m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127 - 8*(4*c+k) -: 8];
      for (int k = 0; k < 4; k++)
        r[127 - 8*(4*c+k) -: 8] = gf_mult(a[k], m[0]) ^ gf_mult(a[(k+1)%4], m[1]) ^
                                  gf_mult(a[(k+2)%4], m[2]) ^ gf_mult(a[(k+3)%4], m[3]);
    end
    return r;
  endfunction

  function automatic logic [127:0] shift_state(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8*(r + 4*((c+r)%4)) -: 8] = s[127 - 8*(r + 4*c) -: 8];
        else t[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c+r)%4)) -: 8];
      end
    return t;
  endfunction

  function automatic logic [31:0] sub_four(input logic [31:0] w);
    return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
  endfunction

  // key schedule, forward and equivalent inverse
  task automatic expand_schedule();
    logic [31:0] w [aes_pkg::SchedWords];
    logic [31:0] t;
    logic [7:0]  rcon;
    for (int i = 0; i < 8; i++) w[i] = i[0] ? key_words[i/2][31:0] : key_words[i/2][63:32];
    rcon = 8'h01;
    for (int i = 8; i < aes_pkg::SchedWords; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = sub_four({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_mult(rcon, 8'h02);
      end else if (i % 8 == 4) begin
        t = sub_four(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r <= aes_pkg::NumRounds; r++)
      enc_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    for (int r = 0; r <= aes_pkg::NumRounds; r++) begin
      dec_keys[r] = enc_keys[aes_pkg::NumRounds - r];
      if (r != 0 && r != aes_pkg::NumRounds) dec_keys[r] = mix_state(dec_keys[r], 1'b1);
    end
  endtask

  function automatic logic [127:0] cipher_block(input logic [127:0] s, input logic decrypt);
    s = s ^ (decrypt ? dec_keys[0] : enc_keys[0]);
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      if (!decrypt) begin
        for (int i = 0; i < 16; i++) s[127 - 8*i -: 8] = fwd_sub(s[127 - 8*i -: 8]);
        s = shift_state(s, 1'b0);
        if (r != aes_pkg::NumRounds) s = mix_state(s, 1'b0);
        s = s ^ enc_keys[r];
      end else begin
        s = shift_state(s, 1'b1);
        for (int i = 0; i < 16; i++) s[127 - 8*i -: 8] = rev_sub(s[127 - 8*i -: 8]);
        if (r != aes_pkg::NumRounds) s = mix_state(s, 1'b1);
        s = s ^ dec_keys[r];
      end
    end
    return s;
  endfunction

  // key tracking, prediction and compare
  always @(posedge clk) begin
    cipher_word_t exp_w;
    logic [127:0] res;
    if (rst) begin
      key_words = '{default: 64'h0};
      expand_schedule();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        key_words[cfg_index] = cfg_data;
        expand_schedule();
      end
      if (din.valid && din.ready) begin
        res = cipher_block({din.block_in_high, din.block_in_low}, din.func);
        expected_words.push_back('{res[127:64], res[63:0], din.last_in});
      end
      if (dout.valid && dout.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h %h %b", $time, dout.block_out_high,
                   dout.block_out_low, dout.last_out);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (dout.block_out_high !== exp_w.hi) begin
            $display("%0t: block_out_high exp %h got %h", $time, exp_w.hi, dout.block_out_high);
            fail_count++;
          end
          if (dout.block_out_low !== exp_w.lo) begin
            $display("%0t: block_out_low exp %h got %h", $time, exp_w.lo, dout.block_out_low);
            fail_count++;
          end
          if (dout.last_out !== exp_w.last) begin
            $display("%0t: last_out exp %b got %b", $time, exp_w.last, dout.last_out);
            fail_count++;
          end
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

@@ dv/aes256_block_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// AES-256 block cipher testbench
// Drives keys and bursty random blocks with a stalling receiver; the checker
// beside the block predicts every output word and counts mismatches.
// ----------------------------------------------------------------------------
module aes256_block_cipher_tb;

  localparam int CycleLimit = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = aes_pkg::REG_KEY0;
  logic [63:0] cfg_data = '0;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  int          sent_words = 0;
  logic        stall_mode = 1'b0;

  aes_in_if  din ();
  aes_out_if dout ();

  aes256_block_cipher dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .din(din.sink), .dout(dout.source)
  );

  aes256_block_cipher_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .din(din.sink), .dout(dout.sink), .fail_count(fail_count),
    .pending_words(pending_words)
  );

  always #5 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("aes256_block_cipher_tb: errors");
      $finish;
    end
  end

  // receiver stall pattern, free-running or heavy in turns
  always @(negedge clk) begin
    if (rst) dout.ready <= 1'b0;
    else if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    else dout.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the block to drain before touching keys
  task automatic drain();
    while (pending_words != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_block(input logic func, input logic [63:0] hi, input logic [63:0] lo,
                            input logic last);
    din.valid <= 1'b1;
    din.func <= func;
    din.block_in_high <= hi;
    din.block_in_low <= lo;
    din.last_in <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_burst(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      send_block($urandom_range(0, 1), rand64(), rand64(), $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        din.valid <= 1'b0;
        gap = $urandom_range(1, 40);
        repeat (gap) @(negedge clk);
      end
    end
    din.valid <= 1'b0;
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    drain();
    write_key(aes_pkg::REG_KEY0, k0);
    write_key(aes_pkg::REG_KEY1, k1);
    write_key(aes_pkg::REG_KEY2, k2);
    write_key(aes_pkg::REG_KEY3, k3);
  endtask

  initial begin
    din.valid = 1'b0;
    din.func = 1'b0;
    din.block_in_high = '0;
    din.block_in_low = '0;
    din.last_in = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero key, extremes of the block, both directions
    send_block(1'b0, 64'h0, 64'h0, 1'b0);
    send_block(1'b1, 64'h0, 64'h0, 1'b1);
    send_block(1'b0, '1, '1, 1'b1);
    send_block(1'b1, '1, '1, 1'b0);
    din.valid <= 1'b0;

    // standard test vector key
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1);
    send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001, 1'b0);
    din.valid <= 1'b0;

    // all-ones key, then a single key word change between blocks
    load_key('1, '1, '1, '1);
    send_block(1'b0, 64'h0, '1, 1'b1);
    send_block(1'b1, '1, 64'h0, 1'b0);
    din.valid <= 1'b0;
    drain();
    write_key(aes_pkg::REG_KEY2, 64'h0);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    din.valid <= 1'b0;

    // random phases with random keys
    for (int p = 0; p < 8; p++) begin
      load_key(rand64(), rand64(), rand64(), rand64());
      random_burst(105);
    end
    drain();
    load_key('1, 64'h0, '1, 64'h0);
    random_burst(20);

    drain();
    if (fail_count == 0) begin
      $display("aes256_block_cipher_tb: clean");
    end else begin
      $display("aes256_block_cipher_tb: errors");
    end
    $finish;
  end

endmodule
